### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PM_ASSERT(label, clk, rst_n, prop, msg)
`define PM_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### rtl/pmul_pkg.sv
// ----------------------------------------------------------------------------
// pmul_pkg
// Shared types and constants of the polynomial multiplier.
// ----------------------------------------------------------------------------
package pmul_pkg;

    localparam int DATA_W     = 32;
    localparam int CMD_W      = 2;
    localparam int POWER_W    = 5;
    localparam int TERM_IDX_W = 5;
    localparam int TERM_CNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_ISSUE
    } pmul_state_t;

    typedef struct packed {
        logic                  load_first;
        logic                  load_second;
        logic                  clear_counts;
        logic                  op_valid;
        logic                  op_first;
        logic                  op_last;
        logic                  op_zero;
        logic                  op_final;
        logic [TERM_IDX_W-1:0] op_i;
        logic [TERM_IDX_W-1:0] op_j;
        logic [POWER_W-1:0]    op_power;
    } pmul_cmd_t;

    typedef struct packed {
        logic [TERM_CNT_W-1:0] first_count;
        logic [TERM_CNT_W-1:0] second_count;
        logic                  busy;
    } pmul_status_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               zero;
        logic               final_coef;
        logic [POWER_W-1:0] power;
    } pmul_tag_t;

endpackage

### rtl/polynomial_multiply_top.sv
// ----------------------------------------------------------------------------
// polynomial_multiply_top
// Polynomial multiplier by full convolution of two loaded coefficient vectors.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per cycle while idle. Command
// load-first or load-second appends the coefficient to that vector, lowest
// power first; a load into a full vector is dropped and sets a sticky flag.
// Command start emits first_count + second_count words on the output channel
// (out_valid/out_ready), powers ascending, last set on the final one, then
// clears both counts. Loads and unused codes give no output word.
// Sequencing: start keeps in_ready low until the last term pair of the
// product has been issued; the term pairs i+j=k of each product coefficient
// k pass one after another through a single multiply-accumulate unit, by
// way of memory read, multiply, accumulate and output handoff.
// A stalled receiver holds the output register and the next coefficient
// waits for it. Reset clears counts, drop flag and all valid state; stored
// coefficients are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module polynomial_multiply_top #(
    parameter int MAX_TERMS   = 16,
    parameter int COEFF_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [pmul_pkg::CMD_W-1:0]           command,
    input  logic signed [pmul_pkg::DATA_W-1:0]   coefficient,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pmul_pkg::DATA_W-1:0]   product_coefficient,
    output logic [pmul_pkg::POWER_W-1:0]         power,
    output logic                                 last,
    output logic                                 overflow_seen
);
    import pmul_pkg::*;

    pmul_cmd_t         cmd;
    pmul_status_t      status;
    logic [DATA_W-1:0] product_word;

    pmul_controller #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    pmul_datapath #(
        .MAX_TERMS   (MAX_TERMS),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .coefficient         (coefficient),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .product_coefficient (product_word),
        .power               (power),
        .last                (last),
        .overflow_seen       (overflow_seen)
    );

    assign product_coefficient = product_word;

endmodule

### rtl/pmul_datapath.sv
// ----------------------------------------------------------------------------
// pmul_datapath
// Coefficient memories, multiply-accumulate pipeline and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmul_datapath #(
    parameter int MAX_TERMS   = 16,
    parameter int COEFF_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pmul_pkg::pmul_cmd_t             cmd,
    output pmul_pkg::pmul_status_t          status,
    input  logic [pmul_pkg::DATA_W-1:0]     coefficient,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pmul_pkg::DATA_W-1:0]     product_coefficient,
    output logic [pmul_pkg::POWER_W-1:0]    power,
    output logic                            last,
    output logic                            overflow_seen
);
    import pmul_pkg::*;

    localparam int ACC_W = (COEFF_WIDTH < DATA_W) ? COEFF_WIDTH : DATA_W;
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [ACC_W-1:0]   first_ram [MAX_TERMS];
    logic [ACC_W-1:0]   second_ram [MAX_TERMS];

    logic [CNT_W-1:0]   first_cnt_reg;
    logic [CNT_W-1:0]   second_cnt_reg;
    logic               dropped_reg;
    logic               room_first;
    logic               room_second;
    logic               wr_first;
    logic               wr_second;

    logic [ACC_W-1:0]   a_rd_reg;
    logic [ACC_W-1:0]   b_rd_reg;
    logic [ACC_W-1:0]   prod_reg;
    logic [ACC_W-1:0]   prod_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    pmul_tag_t          s1_tag_reg;
    pmul_tag_t          s1_tag_next;
    pmul_tag_t          s2_tag_reg;
    logic               load_out;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_coef_reg;
    logic [POWER_W-1:0] out_power_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    assign room_first  = first_cnt_reg < CNT_W'(MAX_TERMS);
    assign room_second = second_cnt_reg < CNT_W'(MAX_TERMS);
    assign wr_first    = cmd.load_first && room_first;
    assign wr_second   = cmd.load_second && room_second;

    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            first_ram[first_cnt_reg[IDX_W-1:0]] <= coefficient[ACC_W-1:0];
        end
        a_rd_reg <= first_ram[cmd.op_i[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_second)
        begin
            second_ram[second_cnt_reg[IDX_W-1:0]] <= coefficient[ACC_W-1:0];
        end
        b_rd_reg <= second_ram[cmd.op_j[IDX_W-1:0]];
    end

    always_comb
    begin
        s1_tag_next.valid      = cmd.op_valid;
        s1_tag_next.first      = cmd.op_first;
        s1_tag_next.last       = cmd.op_last;
        s1_tag_next.zero       = cmd.op_zero;
        s1_tag_next.final_coef = cmd.op_final;
        s1_tag_next.power      = cmd.op_power;
    end

    assign prod_next = a_rd_reg * b_rd_reg;
    assign acc_next  = (s2_tag_reg.first ? '0 : acc_reg) + prod_reg;
    assign load_out  = s2_tag_reg.valid && s2_tag_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            dropped_reg    <= 1'b0;
            s1_tag_reg     <= '0;
            s2_tag_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_counts)
            begin
                first_cnt_reg  <= '0;
                second_cnt_reg <= '0;
            end
            else
            begin
                if (wr_first)
                begin
                    first_cnt_reg <= first_cnt_reg + CNT_W'(1);
                end
                if (wr_second)
                begin
                    second_cnt_reg <= second_cnt_reg + CNT_W'(1);
                end
            end
            if ((cmd.load_first && !room_first) || (cmd.load_second && !room_second))
            begin
                dropped_reg <= 1'b1;
            end
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s1_tag_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= s1_tag_reg.zero ? '0 : prod_next;
        if (s2_tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (load_out)
        begin
            out_coef_reg  <= DATA_W'(acc_next);
            out_power_reg <= s2_tag_reg.power;
            out_last_reg  <= s2_tag_reg.final_coef;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign status.first_count  = TERM_CNT_W'(first_cnt_reg);
    assign status.second_count = TERM_CNT_W'(second_cnt_reg);
    assign status.busy         = s1_tag_reg.valid || s2_tag_reg.valid || out_valid_reg;

    assign out_valid           = out_valid_reg;
    assign product_coefficient = out_coef_reg;
    assign power               = out_power_reg;
    assign last                = out_last_reg;
    assign overflow_seen       = out_ovf_reg;

    `PM_NEVER(a_no_overrun, clk, rst_n, load_out && out_valid_reg, "output word overwritten")
    `PM_ASSERT(a_drop_sticky, clk, rst_n, dropped_reg |=> dropped_reg, "drop flag cleared")
    `PM_ASSERT(a_cnt_bound, clk, rst_n, (first_cnt_reg <= CNT_W'(MAX_TERMS)) && (second_cnt_reg <= CNT_W'(MAX_TERMS)), "count past capacity")

endmodule

### rtl/pmul_controller.sv
// ----------------------------------------------------------------------------
// pmul_controller
// Command decode and convolution sequencer, one product term per cycle while issuing a coefficient.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmul_controller #(
    parameter int MAX_TERMS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pmul_pkg::CMD_W-1:0]    command,
    input  pmul_pkg::pmul_status_t        status,
    output pmul_pkg::pmul_cmd_t           cmd
);
    import pmul_pkg::*;

    localparam int TOT_W = $clog2(2 * MAX_TERMS + 1);

    pmul_state_t      state_reg;
    pmul_state_t      state_next;
    logic [TOT_W-1:0] k_reg;
    logic [TOT_W-1:0] k_next;
    logic [TOT_W-1:0] i_reg;
    logic [TOT_W-1:0] i_next;
    logic [TOT_W-1:0] hi_reg;
    logic [TOT_W-1:0] hi_next;
    logic             empty_reg;
    logic             empty_next;
    logic             first_reg;
    logic             first_next;

    logic [TOT_W-1:0] fc;
    logic [TOT_W-1:0] sc;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] lo;
    logic [TOT_W-1:0] hi;
    logic             empty_now;
    logic [TOT_W-1:0] j_full;
    logic             op_last;

    assign fc        = TOT_W'(status.first_count);
    assign sc        = TOT_W'(status.second_count);
    assign total     = fc + sc;
    assign lo        = (k_reg >= sc) ? (k_reg - sc + TOT_W'(1)) : '0;
    assign hi        = (k_reg < fc) ? k_reg : (fc - TOT_W'(1));
    assign empty_now = (fc == '0) || (sc == '0) || (lo > hi);
    assign j_full    = k_reg - i_reg;
    assign op_last   = empty_reg || (i_reg == hi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            hi_reg    <= '0;
            empty_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            hi_reg    <= hi_next;
            empty_reg <= empty_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        hi_next    = hi_reg;
        empty_next = empty_reg;
        first_next = first_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (command)
                        CMD_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        CMD_LOAD_SECOND: cmd.load_second = 1'b1;
                        CMD_START:
                        begin
                            if (total != '0)
                            begin
                                k_next     = '0;
                                state_next = ST_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (!status.busy)
                begin
                    empty_next = empty_now;
                    i_next     = empty_now ? '0 : lo;
                    hi_next    = hi;
                    first_next = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.op_valid = 1'b1;
                cmd.op_first = first_reg;
                cmd.op_last  = op_last;
                cmd.op_zero  = empty_reg;
                cmd.op_final = (k_reg == total - TOT_W'(1));
                cmd.op_i     = empty_reg ? '0 : TERM_IDX_W'(i_reg);
                cmd.op_j     = empty_reg ? '0 : TERM_IDX_W'(j_full);
                cmd.op_power = POWER_W'(k_reg);
                first_next   = 1'b0;
                i_next       = i_reg + TOT_W'(1);
                if (op_last)
                begin
                    k_next = k_reg + TOT_W'(1);
                    if (k_reg + TOT_W'(1) == total)
                    begin
                        cmd.clear_counts = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `PM_ASSERT(a_issue_in_range, clk, rst_n, (state_reg == ST_ISSUE) |-> (k_reg < total), "power past product length")
    `PM_ASSERT(a_issue_bound, clk, rst_n, (state_reg == ST_ISSUE && !empty_reg) |-> (i_reg <= hi_reg), "term index past bound")
    `PM_ASSERT(a_clear_idle, clk, rst_n, cmd.clear_counts |=> (state_reg == ST_IDLE), "clear without return to idle")

endmodule
